// ===== rtl/owm_pkg.sv =====
// Shared types and constants for the 1-Wire bus master.
// Used by owm_cfg, owm_core and one_wire_bus_master; no dependencies.
package owm_pkg;

	localparam int TimeW       = 10;
	localparam int RegCount    = 8;
	localparam int CfgIdxW     = 4;
	localparam int BitsPerByte = 8;
	localparam int BitIdxW     = $clog2(BitsPerByte);
	localparam logic [BitIdxW-1:0] LastBit = BitIdxW'(BitsPerByte - 1);

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_RESET = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_GAP      = 4'd1,
		PH_RST_LOW  = 4'd2,
		PH_RST_WAIT = 4'd3,
		PH_RST_REC  = 4'd4,
		PH_W1_LOW   = 4'd5,
		PH_W1_REL   = 4'd6,
		PH_W0_LOW   = 4'd7,
		PH_RD_LOW   = 4'd8,
		PH_RD_WAIT  = 4'd9,
		PH_RD_TAIL  = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		REG_RESET_LOW  = 3'd0,
		REG_PRES_DELAY = 3'd1,
		REG_RESET_REC  = 3'd2,
		REG_LONG_SLOT  = 3'd3,
		REG_SHORT_LOW  = 3'd4,
		REG_READ_DELAY = 3'd5,
		REG_READ_TAIL  = 3'd6,
		REG_GAP        = 3'd7
	} reg_idx_t;

	typedef logic [RegCount-1:0][TimeW-1:0] times_t;

	// Register defaults, listed from the highest index down to index 0.
	localparam times_t CfgReset = {
		10'd1, 10'd45, 10'd15, 10'd1, 10'd60, 10'd420, 10'd60, 10'd480
	};

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       line_level;
	} item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] rx_byte;
	} res_t;

endpackage

// ===== rtl/owm_cfg.sv =====
// Timing register file of the 1-Wire bus master.
// Depends on owm_pkg; presents every time with zero read as one.
module owm_cfg
	import owm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [TimeW-1:0]   wr_data,
	output times_t             times
);

	times_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CfgReset;
		end else if (wr_en && wr_index < CfgIdxW'(RegCount)) begin
			regs_q[wr_index[$clog2(RegCount)-1:0]] <= wr_data;
		end
	end

	always_comb begin
		for (int i = 0; i < RegCount; i++) begin
			times[i] = (regs_q[i] == '0) ? TimeW'(1) : regs_q[i];
		end
	end

endmodule

// ===== rtl/owm_core.sv =====
// Slot timing state machine of the 1-Wire bus master.
// Depends on owm_pkg; one item is consumed per accepted beat.
module owm_core
	import owm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  item_t  item,
	input  times_t times,
	output res_t   res,
	output logic   busy
);

	phase_t              phase_q, phase_d;
	cmd_t                op_q, op_d;
	logic [TimeW-1:0]    tl_q, tl_d, tl_dec;
	logic [BitIdxW-1:0]  bit_q, bit_d;
	logic [7:0]          tx_q, tx_d;
	logic [7:0]          rx_q, rx_d;
	logic                pres_q, pres_d;
	logic                done;
	logic                drive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= CMD_TICK;
			tl_q   <= '0;
			bit_q  <= '0;
			tx_q   <= '0;
			rx_q   <= '0;
			pres_q <= 1'b0;
		end else if (accept) begin
			op_q   <= op_d;
			tl_q   <= tl_d;
			bit_q  <= bit_d;
			tx_q   <= tx_d;
			rx_q   <= rx_d;
			pres_q <= pres_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		tl_d    = tl_q;
		bit_d   = bit_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		pres_d  = pres_q;
		done    = 1'b0;
		tl_dec  = (tl_q != '0) ? tl_q - TimeW'(1) : '0;
		// drive reflects the phase in force during this beat
		drive   = (phase_q == PH_RST_LOW) || (phase_q == PH_W1_LOW) ||
		          (phase_q == PH_W0_LOW) || (phase_q == PH_RD_LOW);

		if (item.cmd != CMD_TICK) begin
			// commands are dropped while an operation runs
			if (phase_q == PH_IDLE) begin
				op_d  = item.cmd;
				bit_d = '0;
				if (item.cmd == CMD_WRITE) begin
					tx_d = item.tx_byte;
				end
				if (item.cmd == CMD_READ) begin
					rx_d = '0;
				end
				phase_d = PH_GAP;
				tl_d    = times[REG_GAP];
			end
		end else if (phase_q != PH_IDLE) begin
			tl_d = tl_dec;
			if (tl_dec == '0) begin
				case (phase_q)
					PH_GAP: begin
						case (op_q)
							CMD_RESET: begin
								phase_d = PH_RST_LOW;
								tl_d    = times[REG_RESET_LOW];
							end
							CMD_WRITE: begin
								if (tx_q[bit_q]) begin
									phase_d = PH_W1_LOW;
									tl_d    = times[REG_SHORT_LOW];
								end else begin
									phase_d = PH_W0_LOW;
									tl_d    = times[REG_LONG_SLOT];
								end
							end
							default: begin
								phase_d = PH_RD_LOW;
								tl_d    = times[REG_SHORT_LOW];
							end
						endcase
					end
					PH_RST_LOW: begin
						phase_d = PH_RST_WAIT;
						tl_d    = times[REG_PRES_DELAY];
					end
					PH_RST_WAIT: begin
						pres_d  = ~item.line_level;
						phase_d = PH_RST_REC;
						tl_d    = times[REG_RESET_REC];
					end
					PH_W1_LOW: begin
						phase_d = PH_W1_REL;
						tl_d    = times[REG_LONG_SLOT];
					end
					PH_RD_LOW: begin
						phase_d = PH_RD_WAIT;
						tl_d    = times[REG_READ_DELAY];
					end
					PH_RD_WAIT: begin
						if (item.line_level) begin
							rx_d[bit_q] = 1'b1;
						end
						phase_d = PH_RD_TAIL;
						tl_d    = times[REG_READ_TAIL];
					end
					PH_W1_REL, PH_W0_LOW, PH_RD_TAIL: begin
						if (bit_q == LastBit) begin
							phase_d = PH_IDLE;
							tl_d    = '0;
							bit_d   = '0;
							done    = 1'b1;
						end else begin
							bit_d   = bit_q + BitIdxW'(1);
							phase_d = PH_GAP;
							tl_d    = times[REG_GAP];
						end
					end
					default: begin
						// end of reset recovery
						phase_d = PH_IDLE;
						tl_d    = '0;
						done    = 1'b1;
					end
				endcase
			end
		end

		res.drive_low = drive;
		res.busy_res  = (phase_d != PH_IDLE);
		res.done_res  = done;
		res.presence  = pres_d;
		res.rx_byte   = rx_d;
	end

	assign busy = (phase_q != PH_IDLE);

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// Top level of the 1-Wire bus master: timing registers, slot state machine
// and result register. Depends on owm_pkg, owm_cfg and owm_core.
//
//   channel | signals                          | direction
//   item    | item_valid, item_ready, item     | in  (cmd, tx_byte, line_level)
//   res     | res_valid, res_ready, res        | out (drive_low .. rx_byte)
//   cfg     | cfg_valid, cfg_ready, cfg_index, | in  (register index, 10-bit time)
//           | cfg_data                         |
//
// One item per cycle while item_ready is high: the state machine updates in the
// cycle the item is taken, and the result register shows it on the next cycle.
// item_ready drops only while a held result is not being taken.
// Reset is asynchronous and loads the default bus timings; cfg_ready is
// always high and a write to an index past the last register is ignored.
module one_wire_bus_master
	import owm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  item_t              item,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TimeW-1:0]   cfg_data
);

	times_t times;
	res_t   res_d;
	res_t   res_q;
	logic   res_valid_q;
	logic   accept;
	logic   busy;

	assign cfg_ready  = 1'b1;
	assign item_ready = !res_valid_q || res_ready;
	assign accept     = item_valid && item_ready;

	owm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.times    (times)
	);

	owm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.times  (times),
		.res    (res_d),
		.busy   (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	// a held beat always describes the machine as it stands now
	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.busy_res == busy))
		else $error("result busy flag disagrees with state machine");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done_res) |-> !res_q.busy_res)
		else $error("operation reported done while still busy");

	a_drive_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.drive_low) |-> (res_q.busy_res || res_q.done_res))
		else $error("line driven low outside an operation");
`endif

endmodule
